>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and helpers for the pressure and temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_HI = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_P9 = 2'd3;

    localparam logic signed [31:0] TEMP_MIN = -32'sd4000;
    localparam logic signed [31:0] TEMP_MAX = 32'sd8500;
    localparam logic [31:0] PRES_MIN     = 32'd30000;
    localparam logic [31:0] PRES_MAX     = 32'd110000;
    localparam logic [31:0] FINE_OFFSET  = 32'd64000;
    localparam logic [31:0] PRES_BASE    = 32'd1048576;
    localparam logic [31:0] PRES_SCALE   = 32'd3125;
    localparam logic [31:0] DIV_OFFSET   = 32'd32768;
    localparam logic [31:0] TEMP_ROUND   = 32'd128;
    localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

    // Calibration coefficients, each sign- or zero-extended to a word.
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
    } t_coef;

    // Values that ride alongside the divider.
    typedef struct packed {
        logic [14:0] temp;
        logic [31:0] fine;
        logic        zero;
        logic        dbl;
    } t_side;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Signed division by a power of two, truncating toward zero.
    function automatic logic [31:0] sdiv(input logic [31:0] x, input int unsigned k);
        logic [31:0] m;
        m = (32'd0 - x) >> k;
        return x[31] ? (32'd0 - m) : (x >> k);
    endfunction

endpackage

`default_nettype wire

>>> rtl/ptc_front.sv
// ----------------------------------------------------------------------------
// ptc_front
// Temperature compensation and the pressure terms ahead of the division.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [19:0]   i_rt,
    input  wire logic [19:0]   i_rp,
    input  ptc_pkg::t_coef     i_coef,
    output logic               o_valid,
    output logic [31:0]        o_num,
    output logic [31:0]        o_den,
    output ptc_pkg::t_side     o_side
);

    localparam int unsigned NSTAGE = 11;

    logic [NSTAGE-1:0] r_v;

    logic [31:0] r1_ta, r1_tb;
    logic [19:0] r1_rp, r2_rp, r3_rp, r4_rp, r5_rp, r6_rp, r7_rp, r8_rp, r9_rp;
    logic [31:0] r2_m1, r2_m2;
    logic [31:0] r3_a, r3_m3;
    logic [31:0] r4_fine;
    logic [31:0] r5_fine, r6_fine, r7_fine, r8_fine, r9_fine, r10_fine, r11_fine;
    logic [14:0] r5_temp, r6_temp, r7_temp, r8_temp, r9_temp, r10_temp, r11_temp;
    logic [31:0] r5_pa, r5_q;
    logic [31:0] r6_sq, r6_m5, r6_d;
    logic [31:0] r7_b6, r7_c0, r7_m5, r7_d;
    logic [31:0] r8_b, r8_a;
    logic [31:0] r9_b, r9_am;
    logic [31:0] r10_den, r10_pw;
    logic [31:0] r11_num, r11_den;
    logic        r11_zero, r11_dbl;

    logic [31:0] n5_tm, n5_temp, n5_pa;
    logic [14:0] n5_tclamp;
    logic [31:0] n8_b, n8_a;
    logic [31:0] n10_v5;

    always_comb begin
        n5_tm   = r4_fine + (r4_fine << 2) + ptc_pkg::TEMP_ROUND;
        n5_temp = ptc_pkg::sdiv(n5_tm, 8);
        if ($signed(n5_temp) < ptc_pkg::TEMP_MIN) begin
            n5_tclamp = ptc_pkg::TEMP_MIN[14:0];
        end else if ($signed(n5_temp) > ptc_pkg::TEMP_MAX) begin
            n5_tclamp = ptc_pkg::TEMP_MAX[14:0];
        end else begin
            n5_tclamp = n5_temp[14:0];
        end
        n5_pa  = ptc_pkg::sdiv(r4_fine, 1) - ptc_pkg::FINE_OFFSET;
        n8_b   = ptc_pkg::sdiv(r7_b6 + (r7_m5 << 1), 2) + (i_coef.p4 << 16);
        n8_a   = ptc_pkg::sdiv(ptc_pkg::sdiv(r7_c0, 3) + ptc_pkg::sdiv(r7_d, 1), 18);
        n10_v5 = ptc_pkg::PRES_BASE - {12'd0, r9_rp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSTAGE-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ta    <= {15'd0, i_rt[19:3]} - (i_coef.t1 << 1);
            r1_tb    <= {16'd0, i_rt[19:4]} - i_coef.t1;
            r1_rp    <= i_rp;

            r2_m1    <= r1_ta * i_coef.t2;
            r2_m2    <= r1_tb * r1_tb;
            r2_rp    <= r1_rp;

            r3_a     <= ptc_pkg::sdiv(r2_m1, 11);
            r3_m3    <= ptc_pkg::sdiv(r2_m2, 12) * i_coef.t3;
            r3_rp    <= r2_rp;

            r4_fine  <= r3_a + ptc_pkg::sdiv(r3_m3, 14);
            r4_rp    <= r3_rp;

            r5_fine  <= r4_fine;
            r5_temp  <= n5_tclamp;
            r5_pa    <= n5_pa;
            r5_q     <= ptc_pkg::sdiv(n5_pa, 2);
            r5_rp    <= r4_rp;

            r6_sq    <= r5_q * r5_q;
            r6_m5    <= r5_pa * i_coef.p5;
            r6_d     <= i_coef.p2 * r5_pa;
            r6_fine  <= r5_fine;
            r6_temp  <= r5_temp;
            r6_rp    <= r5_rp;

            r7_b6    <= ptc_pkg::sdiv(r6_sq, 11) * i_coef.p6;
            r7_c0    <= i_coef.p3 * ptc_pkg::sdiv(r6_sq, 13);
            r7_m5    <= r6_m5;
            r7_d     <= r6_d;
            r7_fine  <= r6_fine;
            r7_temp  <= r6_temp;
            r7_rp    <= r6_rp;

            r8_b     <= n8_b;
            r8_a     <= n8_a;
            r8_fine  <= r7_fine;
            r8_temp  <= r7_temp;
            r8_rp    <= r7_rp;

            r9_am    <= (ptc_pkg::DIV_OFFSET + r8_a) * i_coef.p1;
            r9_b     <= r8_b;
            r9_fine  <= r8_fine;
            r9_temp  <= r8_temp;
            r9_rp    <= r8_rp;

            r10_den  <= ptc_pkg::sdiv(r9_am, 15);
            r10_pw   <= (n10_v5 - ptc_pkg::sdiv(r9_b, 12)) * ptc_pkg::PRES_SCALE;
            r10_fine <= r9_fine;
            r10_temp <= r9_temp;

            // Large words are divided first and doubled afterwards.
            r11_dbl  <= (r10_pw >= ptc_pkg::SIGN_BIT);
            r11_num  <= (r10_pw >= ptc_pkg::SIGN_BIT) ? r10_pw : (r10_pw << 1);
            r11_den  <= r10_den;
            r11_zero <= (r10_den == 32'd0);
            r11_fine <= r10_fine;
            r11_temp <= r10_temp;
        end
    end

    assign o_valid     = r_v[NSTAGE-1];
    assign o_num       = r11_num;
    assign o_den       = r11_den;
    assign o_side.temp = r11_temp;
    assign o_side.fine = r11_fine;
    assign o_side.zero = r11_zero;
    assign o_side.dbl  = r11_dbl;

endmodule

`default_nettype wire

>>> rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined unsigned 32 by 32 bit divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_num,
    input  wire logic [31:0]   i_den,
    input  ptc_pkg::t_side     i_side,
    output logic               o_valid,
    output logic [31:0]        o_quot,
    output ptc_pkg::t_side     o_side
);

    localparam int unsigned NBIT = 32;

    logic [NBIT-1:0]    r_v;
    logic [31:0]        r_rem  [NBIT];
    logic [31:0]        r_num  [NBIT];
    logic [31:0]        r_den  [NBIT];
    logic [31:0]        r_quot [NBIT];
    ptc_pkg::t_side     r_side [NBIT];

    logic [31:0]        w_rem  [NBIT];
    logic [31:0]        w_num  [NBIT];
    logic [31:0]        w_den  [NBIT];
    logic [31:0]        w_quot [NBIT];
    ptc_pkg::t_side     w_side [NBIT];
    logic [32:0]        w_trial[NBIT];
    logic [NBIT-1:0]    w_fit;

    always_comb begin
        for (int i = 0; i < NBIT; i++) begin
            if (i == 0) begin
                w_rem[i]  = 32'd0;
                w_num[i]  = i_num;
                w_den[i]  = i_den;
                w_quot[i] = 32'd0;
                w_side[i] = i_side;
            end else begin
                w_rem[i]  = r_rem[i-1];
                w_num[i]  = r_num[i-1];
                w_den[i]  = r_den[i-1];
                w_quot[i] = r_quot[i-1];
                w_side[i] = r_side[i-1];
            end
            w_trial[i] = {w_rem[i], w_num[i][31]};
            w_fit[i]   = (w_trial[i] >= {1'b0, w_den[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NBIT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NBIT; i++) begin
                r_rem[i]  <= w_fit[i] ? 32'(w_trial[i] - {1'b0, w_den[i]})
                                      : w_trial[i][31:0];
                r_num[i]  <= w_num[i] << 1;
                r_den[i]  <= w_den[i];
                r_quot[i] <= {w_quot[i][30:0], w_fit[i]};
                r_side[i] <= w_side[i];
            end
        end
    end

    assign o_valid = r_v[NBIT-1];
    assign o_quot  = r_quot[NBIT-1];
    assign o_side  = r_side[NBIT-1];

endmodule

`default_nettype wire

>>> rtl/ptc_back.sv
// ----------------------------------------------------------------------------
// ptc_back
// Pressure correction after the division, clamping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_quot,
    input  ptc_pkg::t_side     i_side,
    input  ptc_pkg::t_coef     i_coef,
    output logic               o_valid,
    output logic [14:0]        o_temp,
    output logic [16:0]        o_pres,
    output logic [31:0]        o_fine
);

    logic [2:0]     r_v;
    logic [31:0]    r1_pres, r1_sqm, r1_m8, r2_pres, r2_m9, r2_d8;
    ptc_pkg::t_side r1_side, r2_side;
    logic [14:0]    r3_temp;
    logic [16:0]    r3_pres;
    logic [31:0]    r3_fine;

    logic [31:0] n1_pres, n1_s3, n3_c, n3_pf;
    logic [16:0] n3_out;

    always_comb begin
        n1_pres = i_side.dbl ? {i_quot[30:0], 1'b0} : i_quot;
        n1_s3   = n1_pres >> 3;
        n3_c    = ptc_pkg::sdiv(r2_m9, 12);
        n3_pf   = r2_pres + ptc_pkg::sdiv(n3_c + r2_d8 + i_coef.p7, 4);
        if (r2_side.zero || n3_pf < ptc_pkg::PRES_MIN) begin
            n3_out = ptc_pkg::PRES_MIN[16:0];
        end else if (n3_pf > ptc_pkg::PRES_MAX) begin
            n3_out = ptc_pkg::PRES_MAX[16:0];
        end else begin
            n3_out = n3_pf[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pres <= n1_pres;
            r1_sqm  <= n1_s3 * n1_s3;
            r1_m8   <= (n1_pres >> 2) * i_coef.p8;
            r1_side <= i_side;

            r2_pres <= r1_pres;
            r2_m9   <= i_coef.p9 * (r1_sqm >> 13);
            r2_d8   <= ptc_pkg::sdiv(r1_m8, 13);
            r2_side <= r1_side;

            r3_temp <= r2_side.temp;
            r3_pres <= n3_out;
            r3_fine <= r2_side.fine;
        end
    end

    assign o_valid = r_v[2];
    assign o_temp  = r3_temp;
    assign o_pres  = r3_pres;
    assign o_fine  = r3_fine;

endmodule

`default_nettype wire

>>> rtl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Integer compensation of raw barometric temperature and pressure readings.
// ----------------------------------------------------------------------------
// One request carries a raw temperature and a raw pressure reading; one result
// carries the clamped temperature, the clamped pressure and the fine
// temperature. The block accepts a request every cycle unless the output is held;
// a result passes through eleven arithmetic stages, the 32 stages of the
// bit-per-stage pressure divider and three correction stages. When the
// output is held the whole pipeline holds with it. Calibration words are to be
// written only while the pipeline is empty; the block does not enforce it.
`default_nettype none

module pressure_temperature_compensation (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ptc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // raw_temperature [19:0], raw_pressure [39:20]
    input  wire logic [39:0]                        i_s_tdata,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // temperature_centi [14:0], pressure_pascal [31:15], fine_temperature [63:32]
    output logic [63:0]                             o_m_tdata
);

    logic [47:0] r_temp_calib;
    logic [63:0] r_press_lo, r_press_hi;
    logic [15:0] r_press_p9;

    ptc_pkg::t_coef w_coef;
    ptc_pkg::t_side w_f_side, w_d_side;
    logic           w_en, w_f_valid, w_d_valid;
    logic [31:0]    w_num, w_den, w_quot, w_fine;
    logic [14:0]    w_temp;
    logic [16:0]    w_pres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_lo   <= '0;
            r_press_hi   <= '0;
            r_press_p9   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ptc_pkg::REG_TEMP_CALIB:     r_temp_calib <= i_cfg_wdata[47:0];
                ptc_pkg::REG_PRESS_CALIB_LO: r_press_lo   <= i_cfg_wdata;
                ptc_pkg::REG_PRESS_CALIB_HI: r_press_hi   <= i_cfg_wdata;
                ptc_pkg::REG_PRESS_CALIB_P9: r_press_p9   <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign w_coef.t1 = {16'd0, r_temp_calib[15:0]};
    assign w_coef.t2 = ptc_pkg::sext16(r_temp_calib[31:16]);
    assign w_coef.t3 = ptc_pkg::sext16(r_temp_calib[47:32]);
    assign w_coef.p1 = {16'd0, r_press_lo[15:0]};
    assign w_coef.p2 = ptc_pkg::sext16(r_press_lo[31:16]);
    assign w_coef.p3 = ptc_pkg::sext16(r_press_lo[47:32]);
    assign w_coef.p4 = ptc_pkg::sext16(r_press_lo[63:48]);
    assign w_coef.p5 = ptc_pkg::sext16(r_press_hi[15:0]);
    assign w_coef.p6 = ptc_pkg::sext16(r_press_hi[31:16]);
    assign w_coef.p7 = ptc_pkg::sext16(r_press_hi[47:32]);
    assign w_coef.p8 = ptc_pkg::sext16(r_press_hi[63:48]);
    assign w_coef.p9 = ptc_pkg::sext16(r_press_p9);

    // The pipeline moves whenever the output register is free or being taken.
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_rt    (i_s_tdata[19:0]),
        .i_rp    (i_s_tdata[39:20]),
        .i_coef  (w_coef),
        .o_valid (w_f_valid),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_side  (w_f_side)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_f_side),
        .o_valid (w_d_valid),
        .o_quot  (w_quot),
        .o_side  (w_d_side)
    );

    ptc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_quot  (w_quot),
        .i_side  (w_d_side),
        .i_coef  (w_coef),
        .o_valid (o_m_tvalid),
        .o_temp  (w_temp),
        .o_pres  (w_pres),
        .o_fine  (w_fine)
    );

    assign o_m_tdata = {w_fine, w_pres, w_temp};

    a_pres_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[31:15] >= 17'd30000 && o_m_tdata[31:15] <= 17'd110000))
        else $error("pressure result outside clamp range");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[14:0]) >= -15'sd4000
                        && $signed(o_m_tdata[14:0]) <= 15'sd8500))
        else $error("temperature result outside clamp range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("request taken while the pipeline is held");

endmodule

`default_nettype wire

>>> tb/pressure_temperature_compensation_checker.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_checker
// Watches the calibration port and both stream channels of the compensation
// block. It keeps its own copy of the calibration words and works out the
// compensated temperature, pressure and fine temperature for every accepted
// request. Each result leaving the block is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pressure_temperature_compensation_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ptc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    // raw_temperature [19:0], raw_pressure [39:20]
    input  wire logic [39:0]                    i_s_tdata,
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    // temperature_centi [14:0], pressure_pascal [31:15], fine_temperature [63:32]
    input  wire logic [63:0]                    i_m_tdata,
    output int                                  o_errors,
    output int                                  o_pending
);

    logic [47:0] temp_coefs;
    logic [63:0] press_coefs_lo;
    logic [63:0] press_coefs_hi;
    logic [15:0] press_coef_p9;
    logic [63:0] expected_results[$];

    // Arithmetic shift that rounds toward zero, as signed C division does.
    function automatic logic [31:0] div_pow2(input logic [31:0] x, input int k);
        logic [31:0] mag;
        mag = (32'd0 - x) >> k;
        if (x[31]) begin
            return 32'd0 - mag;
        end
        return x >> k;
    endfunction

    function automatic logic [31:0] coef(input logic [63:0] w, input int pos, input bit sgn);
        logic [15:0] v;
        v = w[pos +: 16];
        return sgn ? {{16{v[15]}}, v} : {16'd0, v};
    endfunction

    function automatic logic [63:0] compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
        logic [31:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, c, d, fine, temp, q, sq, pres, v5;
        rt = {12'd0, raw_t};
        rp = {12'd0, raw_p};
        t1 = coef({16'd0, temp_coefs}, 0, 1'b0);
        t2 = coef({16'd0, temp_coefs}, 16, 1'b1);
        t3 = coef({16'd0, temp_coefs}, 32, 1'b1);
        p1 = coef(press_coefs_lo, 0, 1'b0);
        p2 = coef(press_coefs_lo, 16, 1'b1);
        p3 = coef(press_coefs_lo, 32, 1'b1);
        p4 = coef(press_coefs_lo, 48, 1'b1);
        p5 = coef(press_coefs_hi, 0, 1'b1);
        p6 = coef(press_coefs_hi, 16, 1'b1);
        p7 = coef(press_coefs_hi, 32, 1'b1);
        p8 = coef(press_coefs_hi, 48, 1'b1);
        p9 = coef({48'd0, press_coef_p9}, 0, 1'b1);

        a = (rt >> 3) - (t1 << 1);
        a = div_pow2(a * t2, 11);
        b = (rt >> 4) - t1;
        b = div_pow2(div_pow2(b * b, 12) * t3, 14);
        fine = a + b;
        temp = div_pow2(fine * 32'd5 + 32'd128, 8);
        if ($signed(temp) < -32'sd4000) begin
            temp = -32'sd4000;
        end else if ($signed(temp) > 32'sd8500) begin
            temp = 32'd8500;
        end

        a = div_pow2(fine, 1) - 32'd64000;
        q = div_pow2(a, 2);
        sq = q * q;
        b = div_pow2(sq, 11) * p6;
        b = b + (a * p5) * 32'd2;
        b = div_pow2(b, 2) + p4 * 32'd65536;
        c = div_pow2(p3 * div_pow2(sq, 13), 3);
        d = div_pow2(p2 * a, 1);
        a = div_pow2(c + d, 18);
        a = div_pow2((32'd32768 + a) * p1, 15);

        if (a != 32'd0) begin
            v5 = 32'd1048576 - rp;
            pres = (v5 - div_pow2(b, 12)) * 32'd3125;
            if (!pres[31]) begin
                pres = (pres << 1) / a;
            end else begin
                pres = (pres / a) * 32'd2;
            end
            c = div_pow2(p9 * (((pres >> 3) * (pres >> 3)) >> 13), 12);
            d = div_pow2((pres >> 2) * p8, 13);
            pres = pres + div_pow2(c + d + p7, 4);
            if (pres < 32'd30000) begin
                pres = 32'd30000;
            end else if (pres > 32'd110000) begin
                pres = 32'd110000;
            end
        end else begin
            pres = 32'd30000;
        end
        return {fine, pres[16:0], temp[14:0]};
    endfunction

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            temp_coefs     <= '0;
            press_coefs_lo <= '0;
            press_coefs_hi <= '0;
            press_coef_p9  <= '0;
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ptc_pkg::REG_TEMP_CALIB:     temp_coefs     <= i_cfg_wdata[47:0];
                    ptc_pkg::REG_PRESS_CALIB_LO: press_coefs_lo <= i_cfg_wdata;
                    ptc_pkg::REG_PRESS_CALIB_HI: press_coefs_hi <= i_cfg_wdata;
                    ptc_pkg::REG_PRESS_CALIB_P9: press_coef_p9  <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(compensate(i_s_tdata[19:0], i_s_tdata[39:20]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10) begin
                        $display("Unexpected result %h", i_m_tdata);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (want[14:0] !== i_m_tdata[14:0] || want[31:15] !== i_m_tdata[31:15]
                            || want[63:32] !== i_m_tdata[63:32]) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10) begin
                            $display({"Mismatch: temp exp %0d got %0d, pres exp %0d got %0d,",
                                      " fine exp %h got %h"},
                                $signed(want[14:0]), $signed(i_m_tdata[14:0]), want[31:15],
                                i_m_tdata[31:15], want[63:32], i_m_tdata[63:32]);
                        end
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/pressure_temperature_compensation_tb.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_tb
// Drives the compensation block through several calibration settings, with
// directed extremes, a zero pressure divisor and random readings under random
// stalls on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pressure_temperature_compensation_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index = ptc_pkg::REG_TEMP_CALIB;
    logic [ptc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    int          errors;
    int          pending;
    bit          quiet = 0;
    bit          long_hold = 0;

    always #10 i_clk = ~i_clk;

    pressure_temperature_compensation DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    pressure_temperature_compensation_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side back-pressure, with one long hold-off on request.
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_p, raw_t};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Waits until the pipeline has drained, then writes all four words.
    task automatic load_calibration(input logic [47:0] tc, input logic [63:0] lo,
                                    input logic [63:0] hi, input logic [15:0] p9);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        cfg_we <= 1'b1; cfg_index <= ptc_pkg::REG_TEMP_CALIB; cfg_wdata <= {16'd0, tc};
        @(posedge i_clk);
        cfg_index <= ptc_pkg::REG_PRESS_CALIB_LO; cfg_wdata <= lo;
        @(posedge i_clk);
        cfg_index <= ptc_pkg::REG_PRESS_CALIB_HI; cfg_wdata <= hi;
        @(posedge i_clk);
        cfg_index <= ptc_pkg::REG_PRESS_CALIB_P9; cfg_wdata <= {$urandom, 16'd0, p9};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_readings(input int count);
        logic [19:0] rt, rp;
        repeat (count) begin
            if ($urandom_range(0, 9) < 6) begin
                rt = 20'($urandom_range(380000, 620000));
                rp = 20'($urandom_range(200000, 520000));
            end else begin
                rt = 20'($urandom);
                rp = 20'($urandom);
            end
            send_reading(rt, rp);
        end
    endtask

    localparam logic [47:0] TEMP_TYPICAL = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] LO_TYPICAL   = {16'd2855, 16'd3024, 16'hD943, 16'd36477};
    localparam logic [63:0] HI_TYPICAL   = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};

    initial begin
        logic [19:0] edge_vals[6];
        edge_vals = '{20'h00000, 20'hFFFFF, 20'h7FFFF, 20'h80000, 20'd519888, 20'd415148};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: the divisor is zero everywhere.
        send_reading(20'd519888, 20'd415148);
        send_reading(20'hFFFFF, 20'h00000);
        random_readings(60);

        load_calibration(TEMP_TYPICAL, LO_TYPICAL, HI_TYPICAL, 16'd6000);
        foreach (edge_vals[i]) begin
            send_reading(edge_vals[i], edge_vals[5 - i]);
            send_reading(edge_vals[i], edge_vals[i]);
        end
        long_hold = 1;
        random_readings(200);

        load_calibration('1, '1, '1, 16'hFFFF);
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        random_readings(150);

        load_calibration({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
                         {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
        send_reading(20'h00000, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'h00000);
        random_readings(150);

        // Zero pressure divisor with otherwise ordinary coefficients.
        load_calibration(TEMP_TYPICAL, {LO_TYPICAL[63:16], 16'd0}, HI_TYPICAL, 16'd6000);
        random_readings(100);

        repeat (3) begin
            load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                             {$urandom, $urandom}, 16'($urandom));
            random_readings(150);
        end

        load_calibration(TEMP_TYPICAL, LO_TYPICAL, HI_TYPICAL, 16'h7FFF);
        quiet = 1;
        random_readings(120);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
